// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== src/ishf_pkg.sv =====
// Package: payload types, constants and SHA-256 helpers for the set fingerprint.
package ishf_pkg;
  localparam int COUNT_BITS = 32;
  localparam int DIGITS = (COUNT_BITS + 6) / 7;
  localparam int QDEPTH = 2;

  typedef enum logic {OP_ADD = 1'b0, OP_FINISH = 1'b1} op_t;

  typedef struct packed {
    logic        operation;
    logic [63:0] id_word3;
    logic [63:0] id_word2;
    logic [63:0] id_word1;
    logic [63:0] id_word0;
  } in_item_t;

  typedef struct packed {
    logic [63:0] print_low;
    logic [63:0] print_high;
    logic        count_overflow;
  } out_item_t;

  // Finish job handed from front to back.
  typedef struct packed {
    logic [255:0]          sum;
    logic [COUNT_BITS-1:0] count;
    logic                  overflow;
  } job_t;

  typedef enum logic [1:0] {HS_IDLE, HS_SCHED, HS_DONE} hs_state_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Build the padded block: sum bytes, varint of the count, pad, bit length.
  function automatic logic [511:0] make_block(input job_t j);
    logic [7:0]  blk [64];
    logic [6:0]  dig [DIGITS];
    logic [63:0] c;
    int          nd;
    int          len;
    logic [63:0] bits;
    logic [511:0] r;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 32; i++) blk[i] = j.sum[8*i +: 8];
    c = 64'(j.count);
    nd = 1;
    for (int i = 0; i < DIGITS; i++) begin
      dig[i] = c[7*i +: 7];
      if (i > 0 && (c >> (7*i)) != 64'd0) nd = i + 1;
    end
    len = 32;
    for (int i = DIGITS; i > 0; i--) begin
      if (i <= nd) begin
        blk[len] = {(i > 1) ? 1'b1 : 1'b0, dig[i-1]};
        len = len + 1;
      end
    end
    blk[len] = 8'h80;
    bits = 64'(len) * 64'd8;
    for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
    for (int i = 0; i < 64; i++) r[511-8*i -: 8] = blk[i];
    return r;
  endfunction
endpackage

// ===== src/ishf_accum.sv =====
// Front end: accumulates the ID sum and count, emits finish jobs.
module ishf_accum (
  input  logic              clk,
  input  logic              rst,
  input  ishf_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_ready,
  output ishf_pkg::job_t    job,
  output logic              job_valid,
  input  logic              job_ready
);
  logic [255:0]                    running_sum;
  logic [ishf_pkg::COUNT_BITS-1:0] item_count;
  logic                            saturated_flag;
  logic                            take;

  // A finish stalls only while the queue is full; adds never stall.
  assign in_ready  = (in_item.operation == ishf_pkg::OP_ADD) || job_ready;
  assign take      = in_valid && in_ready;
  assign job_valid = in_valid && (in_item.operation == ishf_pkg::OP_FINISH);
  assign job       = '{sum: running_sum, count: item_count, overflow: saturated_flag};

  // Advance the set state.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      item_count     <= '0;
      saturated_flag <= 1'b0;
    end else if (take) begin
      if (in_item.operation == ishf_pkg::OP_ADD) begin
        running_sum <= running_sum + {in_item.id_word3, in_item.id_word2,
                                      in_item.id_word1, in_item.id_word0};
        if (&item_count) saturated_flag <= 1'b1;
        else item_count <= item_count + 1'b1;
      end else begin
        running_sum    <= '0;
        item_count     <= '0;
        saturated_flag <= 1'b0;
      end
    end
  end
endmodule

// ===== src/ishf_queue.sv =====
// Short queue of finish jobs between front and back.
module ishf_queue (
  input  logic           clk,
  input  logic           rst,
  input  ishf_pkg::job_t wr_job,
  input  logic           wr_valid,
  output logic           wr_ready,
  output ishf_pkg::job_t rd_job,
  output logic           rd_valid,
  input  logic           rd_ready
);
  ishf_pkg::job_t slots [ishf_pkg::QDEPTH];
  logic wp, rp;
  logic [1:0] fill;

  assign wr_ready = fill != 2'(ishf_pkg::QDEPTH);
  assign rd_valid = fill != 2'd0;
  assign rd_job   = slots[rp];

  // Push and pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      fill <= fill + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slots[wp] <= wr_job;
  end
endmodule

// ===== src/ishf_hash.sv =====
// Back end: one SHA-256 round per cycle, result held in an output register.
module ishf_hash (
  input  logic                clk,
  input  logic                rst,
  input  ishf_pkg::job_t      job,
  input  logic                job_valid,
  output logic                job_ready,
  output ishf_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready
);
  ishf_pkg::hs_state_t state, state_next;
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  round;
  logic        empty, ovf;
  logic [31:0] t1, t2, wn, s0, s1, e, a;
  logic [31:0] h [4];
  logic [511:0] blk;

  // Build the padded message block of the waiting job.
  assign blk = ishf_pkg::make_block(job);

  // Round and schedule logic.
  always_comb begin
    e  = v[4];
    a  = v[0];
    t1 = v[7] + (ishf_pkg::rotr(e, 6) ^ ishf_pkg::rotr(e, 11) ^ ishf_pkg::rotr(e, 25))
         + ((e & v[5]) ^ (~e & v[6])) + ishf_pkg::ROUND_K[round] + w[0];
    t2 = (ishf_pkg::rotr(a, 2) ^ ishf_pkg::rotr(a, 13) ^ ishf_pkg::rotr(a, 22))
         + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
    s0 = ishf_pkg::rotr(w[1], 7) ^ ishf_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = ishf_pkg::rotr(w[14], 17) ^ ishf_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    for (int i = 0; i < 4; i++) h[i] = ishf_pkg::INIT_H[i] + v[i];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ishf_pkg::HS_IDLE:  if (job_valid && !out_valid) state_next = ishf_pkg::HS_SCHED;
      ishf_pkg::HS_SCHED: if (round == 6'd63) state_next = ishf_pkg::HS_DONE;
      ishf_pkg::HS_DONE:  state_next = ishf_pkg::HS_IDLE;
      default:            state_next = ishf_pkg::HS_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    job_ready = (state == ishf_pkg::HS_IDLE) && !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ishf_pkg::HS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ishf_pkg::HS_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Load, iterate and pack the digest.
  always_ff @(posedge clk) begin
    unique case (state)
      ishf_pkg::HS_IDLE: begin
        if (job_valid && job_ready) begin
          for (int i = 0; i < 16; i++)
            w[i] <= blk[511-32*i -: 32];
          for (int i = 0; i < 8; i++) v[i] <= ishf_pkg::INIT_H[i];
          round <= 6'd0;
          empty <= job.count == '0;
          ovf   <= job.overflow;
        end
      end
      ishf_pkg::HS_SCHED: begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wn;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        round <= round + 6'd1;
      end
      ishf_pkg::HS_DONE: begin
        out_item.count_overflow <= ovf;
        for (int i = 0; i < 8; i++) begin
          out_item.print_low[8*i +: 8]  <= empty ? 8'h00 : h[i/4][31-8*(i%4) -: 8];
          out_item.print_high[8*i +: 8] <= empty ? 8'h00 : h[2+i/4][31-8*(i%4) -: 8];
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== src/id_set_sum_hash_fingerprint.sv =====
// Top level of the ID set fingerprint: accumulator, job queue, SHA-256 engine.
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready   | in_item  (ishf_pkg::in_item_t)
//  out     | out | out_valid/out_ready | out_item (ishf_pkg::out_item_t)
// An add item is taken by the 256-bit adder, one per cycle.
// In the hash engine a finish item passes through load, 64 rounds and pack;
// two finishes may queue, adds keep flowing behind them.
// Reset clears the sum, count, flag, queue and engine state.
// A finish stalls only while the queue is full; results wait in the output register.
`include "assert_macros.svh"
module id_set_sum_hash_fingerprint (
  input  logic                clk,
  input  logic                rst,
  input  ishf_pkg::in_item_t  in_item,
  input  logic                in_valid,
  output logic                in_ready,
  output ishf_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready
);
  ishf_pkg::job_t fj, bj;
  logic fv, fr, bv, br;

  ishf_accum u_accum (.clk, .rst, .in_item, .in_valid, .in_ready,
                      .job(fj), .job_valid(fv), .job_ready(fr));
  ishf_queue u_queue (.clk, .rst, .wr_job(fj), .wr_valid(fv), .wr_ready(fr),
                      .rd_job(bj), .rd_valid(bv), .rd_ready(br));
  ishf_hash  u_hash  (.clk, .rst, .job(bj), .job_valid(bv), .job_ready(br),
                      .out_item, .out_valid, .out_ready);

  `ASSERT_IMPLY(a_add_ready, clk, rst, in_item.operation == ishf_pkg::OP_ADD, in_ready)
  `ASSERT_IMPLY(a_no_pop_busy, clk, rst, bv && br, !out_valid)
  `ASSERT_NEXT(a_pop_starts, clk, rst, bv && br, !br)
endmodule
